>>> hdl/utf8_byte_stream_decoder_macros.svh
// assertion helpers shared by the decoder
`ifndef UTF8_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_MACROS_SVH

// same-cycle implication, off while in reset
`define UBSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder check failed");

// next-cycle implication, off while in reset
`define UBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder check failed");

`endif

>>> hdl/utf8_bsd_pkg.sv
package utf8_bsd_pkg;

    localparam logic [15:0] REPLACEMENT_CHAR = 16'h003F;
    localparam logic [15:0] BOM_CHAR         = 16'hFEFF;

    // results caused by one byte, at most two
    typedef struct packed {
        logic [15:0] cp0;
        logic        has0;
        logic [15:0] cp1;
        logic        two;
        logic        last;
    } entry_t;

endpackage

>>> hdl/utf8_bsd_front.sv
module utf8_bsd_front
    import utf8_bsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    input  logic       accept,
    output logic       push,
    output entry_t     entry
);

    logic        strip_bom_reg, strip_bom_next;
    logic [1:0]  pending_reg, pending_next;
    logic [15:0] partial_reg, partial_next;
    logic        start_reg, start_next;

    logic        is_cont;
    logic        open_seq;
    logic        f_emit;
    logic [15:0] f_cp;
    logic [1:0]  f_pend;
    logic [15:0] f_part;
    logic [15:0] joined;
    logic        a_v, b_v, c_v;
    logic [15:0] a_cp, b_cp;
    logic [1:0]  pend_after;
    logic [15:0] part_after;
    logic        drop_a;
    logic        keep_a;
    logic        second_v;
    logic [15:0] second_cp;
    logic        entry_valid;

    assign is_cont  = (byte_value[7:6] == 2'b10);
    assign open_seq = (pending_reg != 2'd0);
    assign joined   = {partial_reg[9:0], byte_value[5:0]};

    // classify the byte as if no sequence were open
    always_comb
    begin
        f_emit = 1'b0;
        f_cp   = REPLACEMENT_CHAR;
        f_pend = 2'd0;
        f_part = 16'd0;
        if (!byte_value[7])
        begin
            f_emit = 1'b1;
            f_cp   = {8'd0, byte_value};
        end
        else if (is_cont)
        begin
            f_emit = 1'b0;
        end
        else if (byte_value[7:5] == 3'b110)
        begin
            f_pend = 2'd1;
            f_part = {11'd0, byte_value[4:0]};
        end
        else if (byte_value[7:4] == 4'b1110)
        begin
            f_pend = 2'd2;
            f_part = {12'd0, byte_value[3:0]};
        end
        else
        begin
            f_emit = 1'b1;
        end
    end

    always_comb
    begin
        a_v        = 1'b0;
        a_cp       = REPLACEMENT_CHAR;
        b_v        = 1'b0;
        b_cp       = f_cp;
        pend_after = f_pend;
        part_after = f_part;
        if (open_seq && is_cont)
        begin
            part_after = joined;
            pend_after = pending_reg - 2'd1;
            if (pending_reg == 2'd1)
            begin
                a_v  = 1'b1;
                a_cp = joined;
            end
        end
        else if (open_seq)
        begin
            // interrupted sequence, then the byte starts afresh
            a_v = 1'b1;
            b_v = f_emit;
        end
        else
        begin
            a_v  = f_emit;
            a_cp = f_cp;
        end
    end

    assign c_v       = last_byte && (pend_after != 2'd0);
    assign drop_a    = a_v && start_reg && strip_bom_reg && (a_cp == BOM_CHAR);
    assign keep_a    = a_v && !drop_a;
    assign second_v  = b_v || c_v;
    assign second_cp = b_v ? b_cp : REPLACEMENT_CHAR;

    always_comb
    begin
        entry.last = last_byte;
        entry.cp1  = second_cp;
        if (keep_a)
        begin
            entry.cp0  = a_cp;
            entry.has0 = 1'b1;
            entry.two  = second_v;
        end
        else if (second_v)
        begin
            entry.cp0  = second_cp;
            entry.has0 = 1'b1;
            entry.two  = 1'b0;
        end
        else
        begin
            // bare end marker when last, otherwise nothing is pushed
            entry.cp0  = 16'd0;
            entry.has0 = 1'b0;
            entry.two  = 1'b0;
        end
    end

    assign entry_valid = keep_a || second_v || last_byte;
    assign push        = accept && entry_valid;

    always_comb
    begin
        strip_bom_next = cfg_write_en ? cfg_write_data : strip_bom_reg;
        pending_next   = pending_reg;
        partial_next   = partial_reg;
        start_next     = start_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pending_next = 2'd0;
                partial_next = 16'd0;
                start_next   = 1'b1;
            end
            else
            begin
                pending_next = pend_after;
                partial_next = part_after;
                if (a_v || b_v)
                begin
                    start_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_bom_reg <= 1'b1;
            pending_reg   <= 2'd0;
            partial_reg   <= 16'd0;
            start_reg     <= 1'b1;
        end
        else
        begin
            strip_bom_reg <= strip_bom_next;
            pending_reg   <= pending_next;
            partial_reg   <= partial_next;
            start_reg     <= start_next;
        end
    end

endmodule

>>> hdl/utf8_bsd_queue.sv
module utf8_bsd_queue
    import utf8_bsd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/utf8_bsd_back.sv
module utf8_bsd_back
    import utf8_bsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_point,
    output logic        has_char,
    output logic        end_of_string,
    output logic        last_of_run
);

    logic        valid_reg, valid_next;
    logic        half_reg, half_next;
    logic [15:0] cp_reg, cp_next;
    logic        has_reg, has_next;
    logic        eos_reg, eos_next;
    logic        lor_reg, lor_next;
    logic        load;

    // output stage is free when empty or its beat leaves this cycle
    assign load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        cp_next    = cp_reg;
        has_next   = has_reg;
        eos_next   = eos_reg;
        lor_next   = lor_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                if (half_reg)
                begin
                    cp_next   = head.cp1;
                    has_next  = 1'b1;
                    eos_next  = head.last;
                    lor_next  = 1'b1;
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
                else
                begin
                    cp_next  = head.cp0;
                    has_next = head.has0;
                    if (head.two)
                    begin
                        eos_next  = 1'b0;
                        lor_next  = 1'b0;
                        half_next = 1'b1;
                    end
                    else
                    begin
                        eos_next = head.last;
                        lor_next = 1'b1;
                        pop      = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg  <= cp_next;
        has_reg <= has_next;
        eos_reg <= eos_next;
        lor_reg <= lor_next;
    end

    assign out_valid     = valid_reg;
    assign code_point    = cp_reg;
    assign has_char      = has_reg;
    assign end_of_string = eos_reg;
    assign last_of_run   = lor_reg;

endmodule

>>> hdl/utf8_byte_stream_decoder.sv
// utf8 byte stream decoder: one utf-8 byte per input beat, 16-bit code points out
// input channel: in_valid/in_ready with byte_value and last_byte (end of string)
// output channel: out_valid/out_ready with code_point, has_char, end_of_string,
//   last_of_run; a byte gives zero, one or two output beats, and a final byte
//   that gives no character still gives one bare end beat (has_char low)
// config: cfg_write_en/cfg_write_data set strip_bom (reset 1) in any cycle,
//   meant to change only while no string is in flight
// datapath: a result is written into the queue, then loaded into the output register
// throughput: one byte per cycle while the queue is not full; a byte with two
//   results holds the output stage for two beats, and the QUEUE_DEPTH entry queue
//   between the decode front and the output stage absorbs that burst
// reset: clears decode state, empties the queue and drops any held result;
//   strip_bom returns to 1
// receiver stall: the output beat holds; the front keeps taking bytes until
//   the queue fills, then in_ready drops
module utf8_byte_stream_decoder
    import utf8_bsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_point,
    output logic        has_char,
    output logic        end_of_string,
    output logic        last_of_run
);

`include "utf8_byte_stream_decoder_macros.svh"

    logic   accept;
    logic   push;
    entry_t push_entry;
    entry_t head;
    logic   q_empty;
    logic   q_full;
    logic   pop;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    utf8_bsd_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .byte_value     (byte_value),
        .last_byte      (last_byte),
        .accept         (accept),
        .push           (push),
        .entry          (push_entry)
    );

    utf8_bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    utf8_bsd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_point    (code_point),
        .has_char      (has_char),
        .end_of_string (end_of_string),
        .last_of_run   (last_of_run)
    );

    // a bare end beat carries nothing and closes both the run and the string
    `UBSD_ASSERT_IMPL(a_bare_end, clk, rst_n, out_valid && !has_char,
        end_of_string && last_of_run && (code_point == 16'd0))

    // the string ends only on the last beat of a run
    `UBSD_ASSERT_IMPL(a_eos_closes_run, clk, rst_n, out_valid && end_of_string, last_of_run)

    // the first beat of a two-beat run is always a character
    `UBSD_ASSERT_IMPL(a_pair_has_char, clk, rst_n, out_valid && !last_of_run, has_char)

    // a final byte always leaves something queued
    `UBSD_ASSERT_NEXT(a_last_queued, clk, rst_n, accept && last_byte, !q_empty)

endmodule

>>> test/tb_utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_byte_stream_decoder;
    import utf8_bsd_pkg::*;

    // one output beat as the decoder should present it
    typedef struct packed {
        logic [15:0] code_point;
        logic        has_char;
        logic        end_of_string;
        logic        last_of_run;
    } cp_beat_t;

    // directed stimulus row; typed rows carry their single expected beat
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       typed;
        cp_beat_t   want;
    } stim_row_t;

    localparam int NUM_ROWS       = 24;
    localparam int NUM_PHASES     = 6;
    localparam int BYTES_PER_PHASE = 275;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic        cfg_write_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_value = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] code_point;
    logic        has_char;
    logic        end_of_string;
    logic        last_of_run;

    // decoder state mirrored by the predictor
    logic [1:0]  dec_pending = 2'd0;
    logic [15:0] dec_partial = 16'h0000;
    logic        dec_at_start = 1'b1;
    logic        dec_strip_bom = 1'b1;

    cp_beat_t    byte_beats[$];
    cp_beat_t    expected_beats[$];
    cp_beat_t    got_want;
    logic [7:0]  string_bytes[$];

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;

    stim_row_t stim_rows [NUM_ROWS] = '{
        '{8'h41, 1'b0, 1'b1, '{16'h0041, 1'b1, 1'b0, 1'b1}},
        '{8'h00, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b1}},
        '{8'h7F, 1'b1, 1'b1, '{16'h007F, 1'b1, 1'b1, 1'b1}},
        // stray continuation closing a string leaves only the bare end beat
        '{8'h80, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b1}},
        '{8'hC3, 1'b0, 1'b0, '0},
        '{8'hA9, 1'b0, 1'b0, '0},
        // lead cut short by ascii: replacement then the ascii char
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b1, '{16'h003F, 1'b1, 1'b0, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, '{16'h003F, 1'b1, 1'b0, 1'b1}},
        '{8'hF8, 1'b0, 1'b1, '{16'h003F, 1'b1, 1'b0, 1'b1}},
        '{8'h9F, 1'b0, 1'b0, '0},
        '{8'hDF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hEF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b1, 1'b0, '0},
        // open sequence at end of string
        '{8'hC0, 1'b1, 1'b1, '{16'h003F, 1'b1, 1'b1, 1'b1}},
        // two marks at string start: first dropped, second kept
        '{8'hEF, 1'b0, 1'b0, '0},
        '{8'hBB, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hEF, 1'b0, 1'b0, '0},
        '{8'hBB, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b1, 1'b0, '0}
    };

    int phase_send_idle [NUM_PHASES] = '{0, 73, 0, 23, 0, 23};
    int phase_stall     [NUM_PHASES] = '{0, 0, 73, 23, 0, 23};
    logic phase_strip   [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    utf8_byte_stream_decoder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_value     (byte_value),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .code_point     (code_point),
        .has_char       (has_char),
        .end_of_string  (end_of_string),
        .last_of_run    (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void emit_code_point(input logic [15:0] cp);
        if (dec_at_start && dec_strip_bom && cp == BOM_CHAR)
        begin
            dec_at_start = 1'b0;
            return;
        end
        dec_at_start = 1'b0;
        byte_beats.insert(byte_beats.size(), cp_beat_t'{cp, 1'b1, 1'b0, 1'b0});
    endfunction

    function automatic void decode_lead(input logic [7:0] v);
        if (!v[7])
            emit_code_point({8'h00, v});
        else if (v[7:6] == 2'b10)
            ; // stray continuation, dropped
        else if (v[7:5] == 3'b110)
        begin
            dec_partial = {11'd0, v[4:0]};
            dec_pending = 2'd1;
        end
        else if (v[7:4] == 4'b1110)
        begin
            dec_partial = {12'd0, v[3:0]};
            dec_pending = 2'd2;
        end
        else
            emit_code_point(REPLACEMENT_CHAR);
    endfunction

    function automatic void decode_byte(input logic [7:0] v, input logic last);
        int n;
        byte_beats.delete();
        if (dec_pending != 2'd0)
        begin
            if (v[7:6] == 2'b10)
            begin
                dec_partial = {dec_partial[9:0], v[5:0]};
                dec_pending = dec_pending - 2'd1;
                if (dec_pending == 2'd0)
                    emit_code_point(dec_partial);
            end
            else
            begin
                dec_pending = 2'd0;
                emit_code_point(REPLACEMENT_CHAR);
                decode_lead(v);
            end
        end
        else
            decode_lead(v);
        if (last)
        begin
            if (dec_pending != 2'd0)
            begin
                dec_pending = 2'd0;
                emit_code_point(REPLACEMENT_CHAR);
            end
            if (byte_beats.size() == 0)
                byte_beats.insert(0, cp_beat_t'{16'h0000, 1'b0, 1'b1, 1'b0});
            else
                byte_beats[byte_beats.size() - 1].end_of_string = 1'b1;
            dec_pending = 2'd0;
            dec_partial = 16'h0000;
            dec_at_start = 1'b1;
        end
        n = byte_beats.size();
        if (n > 0)
            byte_beats[n - 1].last_of_run = 1'b1;
        foreach (byte_beats[i])
            expected_beats.insert(expected_beats.size(), byte_beats[i]);
    endfunction

    task automatic send_byte(input logic [7:0] v, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        byte_value <= v;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        decode_byte(v, last);
    endtask

    task automatic wait_drained();
        while (expected_beats.size() != 0)
            @(posedge clk);
        // beats with no result may still sit in the decoder
        repeat (10) @(posedge clk);
    endtask

    task automatic set_strip_bom(input logic v);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        dec_strip_bom = v;
        cfg_write_en <= 1'b0;
    endtask

    task automatic push_cont();
        int unsigned rnd;
        rnd = $urandom();
        string_bytes.insert(string_bytes.size(), {2'b10, rnd[5:0]});
    endtask

    task automatic push_bom();
        string_bytes.insert(string_bytes.size(), 8'hEF);
        string_bytes.insert(string_bytes.size(), 8'hBB);
        string_bytes.insert(string_bytes.size(), 8'hBF);
    endtask

    // mostly well-formed strings, with replaced, cut-short and stray bytes mixed in
    task automatic build_string();
        int n_chars;
        int kind;
        int unsigned rnd;
        string_bytes.delete();
        n_chars = $urandom_range(6, 1);
        if ($urandom_range(99) < 20)
            push_bom();
        repeat (n_chars)
        begin
            kind = $urandom_range(99);
            rnd = $urandom();
            if (kind < 30)
                string_bytes.insert(string_bytes.size(), {1'b0, rnd[6:0]});
            else if (kind < 55)
            begin
                string_bytes.insert(string_bytes.size(), {3'b110, rnd[4:0]});
                push_cont();
            end
            else if (kind < 80)
            begin
                string_bytes.insert(string_bytes.size(), {4'b1110, rnd[3:0]});
                push_cont();
                push_cont();
            end
            else if (kind < 85)
                push_bom();
            else if (kind < 90)
            begin
                string_bytes.insert(string_bytes.size(), {4'b1111, rnd[3:0]});
                if (rnd[8])
                    push_cont();
            end
            else if (kind < 95)
            begin
                if (rnd[8])
                    string_bytes.insert(string_bytes.size(), {3'b110, rnd[4:0]});
                else
                begin
                    string_bytes.insert(string_bytes.size(), {4'b1110, rnd[3:0]});
                    if (rnd[9])
                        push_cont();
                end
            end
            else
                string_bytes.insert(string_bytes.size(), rnd[7:0]);
        end
    endtask

    // receiver: check accepted beats in order, then pick ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: code_point %h has_char %b", code_point, has_char);
                mismatches = mismatches + 1;
            end
            else
            begin
                got_want = expected_beats.pop_front();
                if (code_point !== got_want.code_point)
                begin
                    $error("code_point: expected %h, got %h", got_want.code_point, code_point);
                    mismatches = mismatches + 1;
                end
                if (has_char !== got_want.has_char)
                begin
                    $error("has_char: expected %b, got %b", got_want.has_char, has_char);
                    mismatches = mismatches + 1;
                end
                if (end_of_string !== got_want.end_of_string)
                begin
                    $error("end_of_string: expected %b, got %b",
                           got_want.end_of_string, end_of_string);
                    mismatches = mismatches + 1;
                end
                if (last_of_run !== got_want.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b", got_want.last_of_run, last_of_run);
                    mismatches = mismatches + 1;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        int sent;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            send_byte(stim_rows[i].value, stim_rows[i].last);
            if (stim_rows[i].typed)
            begin
                void'(expected_beats.pop_back());
                expected_beats.insert(expected_beats.size(), stim_rows[i].want);
            end
        end
        in_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_strip_bom(phase_strip[p]);
            send_idle_pct = phase_send_idle[p];
            stall_pct = phase_stall[p];
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                build_string();
                foreach (string_bytes[i])
                    send_byte(string_bytes[i], i == string_bytes.size() - 1);
                sent = sent + string_bytes.size();
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/utf8_bsd_pkg.sv
hdl/utf8_bsd_front.sv
hdl/utf8_bsd_queue.sv
hdl/utf8_bsd_back.sv
hdl/utf8_byte_stream_decoder.sv
test/tb_utf8_byte_stream_decoder.sv
